### design/u8d_pkg.sv
// Shared types and constants of the UTF-8 to code point decoder.
// Used by the front, queue, back and top level modules; depends on nothing.
package u8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W = 21;
  localparam int unsigned TDATA_OUT_W = 24;
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned RES_CNT_W = 2;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            repl;
  } u8d_res_t;

  // One queue entry: the results one input item causes, first result in res[0].
  typedef struct packed {
    logic [RES_CNT_W-1:0]    num;
    logic                    last;
    u8d_res_t [MAX_RES-1:0]  res;
  } u8d_job_t;

endpackage

### design/u8d_front.sv
// Front part of the decoder: accepts bytes, tracks the open sequence and
// builds one queue entry per item that causes results. Depends on u8d_pkg.
module u8d_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [u8d_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        end_of_text,
  input  logic                        q_full,
  output logic                        push,
  output u8d_pkg::u8d_job_t           push_job
);
  import u8d_pkg::*;

  logic [BYTE_W-1:0] held0, held1, held2;
  logic [BYTE_W-1:0] held0_next, held1_next, held2_next;
  logic [1:0]        held_count, held_count_next;
  logic [2:0]        seq_len, seq_len_next;
  logic              take;

  function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
    if (b[7:5] == 3'b110) return 3'd2;
    if (b[7:4] == 4'b1110) return 3'd3;
    if (b[7:3] == 5'b11110) return 3'd4;
    return 3'd0;
  endfunction

  function automatic u8d_res_t plain(input logic [CP_W-1:0] cp);
    u8d_res_t r;
    r.cp = cp;
    r.repl = 1'b0;
    return r;
  endfunction

  function automatic u8d_res_t repl_res();
    u8d_res_t r;
    r.cp = REPL_CP;
    r.repl = 1'b1;
    return r;
  endfunction

  // A lone byte decoded as a fresh string: ASCII or a replacement.
  function automatic u8d_res_t single(input logic [BYTE_W-1:0] c);
    if (c[7] == 1'b0) return plain({13'd0, c});
    return repl_res();
  endfunction

  assign in_ready = !q_full;
  assign take = in_valid && in_ready;

  always_comb begin
    held0_next = held0;
    held1_next = held1;
    held2_next = held2;
    held_count_next = held_count;
    seq_len_next = seq_len;
    push = 1'b0;
    push_job.num = 2'd1;
    push_job.last = end_of_text;
    push_job.res = '0;
    if (take) begin
      if (seq_len == 3'd0) begin
        if (in_byte[7] == 1'b0) begin
          push = 1'b1;
          push_job.res[0] = plain({13'd0, in_byte});
        end else if (lead_len(in_byte) == 3'd0 || end_of_text) begin
          push = 1'b1;
          push_job.res[0] = repl_res();
        end else begin
          held0_next = in_byte;
          held_count_next = 2'd1;
          seq_len_next = lead_len(in_byte);
        end
      end else if ({1'b0, held_count} + 3'd1 >= seq_len) begin
        // The byte that completes the open sequence.
        push = 1'b1;
        case (seq_len)
          3'd2: push_job.res[0] = plain({10'd0, held0[4:0], in_byte[5:0]});
          3'd3: push_job.res[0] = plain({5'd0, held0[3:0], held1[5:0], in_byte[5:0]});
          default: push_job.res[0] = plain({held0[2:0], held1[5:0], held2[5:0],
                                            in_byte[5:0]});
        endcase
        held_count_next = 2'd0;
        seq_len_next = 3'd0;
      end else if (end_of_text) begin
        // The string ends inside a sequence: replace the lead and decode the
        // held followers and this byte again as a fresh string.
        push = 1'b1;
        push_job.res[0] = repl_res();
        if (held_count == 2'd1) begin
          push_job.num = 2'd2;
          push_job.res[1] = single(in_byte);
        end else if (held1[7] == 1'b0) begin
          push_job.num = 2'd3;
          push_job.res[1] = plain({13'd0, held1});
          push_job.res[2] = single(in_byte);
        end else if (lead_len(held1) == 3'd2) begin
          push_job.num = 2'd2;
          push_job.res[1] = plain({10'd0, held1[4:0], in_byte[5:0]});
        end else begin
          push_job.num = 2'd3;
          push_job.res[1] = repl_res();
          push_job.res[2] = single(in_byte);
        end
        held_count_next = 2'd0;
        seq_len_next = 3'd0;
      end else begin
        if (held_count == 2'd1) begin
          held1_next = in_byte;
        end else begin
          held2_next = in_byte;
        end
        held_count_next = held_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      seq_len <= 3'd0;
    end else begin
      held_count <= held_count_next;
      seq_len <= seq_len_next;
    end
  end

  always_ff @(posedge clk) begin
    held0 <= held0_next;
    held1 <= held1_next;
    held2 <= held2_next;
  end

`ifndef ASSERT_OFF
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    seq_len == 3'd0 |-> held_count == 2'd0)
    else $error("bytes held with no sequence open");
  a_open_count: assert property (@(posedge clk) disable iff (rst)
    seq_len != 3'd0 |-> held_count != 2'd0 && {1'b0, held_count} < seq_len)
    else $error("held byte count out of range for the open sequence");
`endif

endmodule

### design/u8d_queue.sv
// Short queue of decoded entries between the front and back parts.
// Depends on u8d_pkg for the entry type.
module u8d_queue #(
  parameter int unsigned DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u8d_pkg::u8d_job_t  push_job,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output u8d_pkg::u8d_job_t  head
);
  import u8d_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u8d_job_t         entries [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  assign full = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= bump(wptr);
      if (pop) rptr <= bump(rptr);
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_job;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("entry pushed into a full queue");
`endif

endmodule

### design/u8d_back.sv
// Back part of the decoder: steps through the results of the head entry
// and drives the registered output stage. Depends on u8d_pkg.
module u8d_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       not_empty,
  input  u8d_pkg::u8d_job_t          head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [u8d_pkg::CP_W-1:0]   code_point,
  output logic                       is_replacement,
  output logic                       final_result
);
  import u8d_pkg::*;

  logic [RES_CNT_W-1:0] sub, sub_next;
  logic                 out_valid_next;
  logic                 load;
  logic                 at_end;
  u8d_res_t             cur;

  assign load = not_empty && (!out_valid || out_ready);
  assign at_end = (sub == head.num - RES_CNT_W'(1));
  assign cur = head.res[sub];
  assign pop = load && at_end;

  always_comb begin
    sub_next = sub;
    if (load) begin
      sub_next = at_end ? '0 : sub + RES_CNT_W'(1);
    end
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= '0;
      out_valid <= 1'b0;
    end else begin
      sub <= sub_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point <= cur.cp;
      is_replacement <= cur.repl;
      final_result <= head.last && at_end;
    end
  end

`ifndef ASSERT_OFF
  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    not_empty |-> head.num != '0)
    else $error("queue entry carries no result");
  a_sub_in_range: assert property (@(posedge clk) disable iff (rst)
    not_empty |-> sub < head.num)
    else $error("result index beyond the head entry");
`endif

endmodule

### design/utf8_to_code_point_decoder_unit.sv
// Top level of the UTF-8 to code point decoder.
// Instantiates u8d_front, u8d_queue and u8d_back; uses u8d_pkg.
//
//   channel  | direction | tdata            | tuser          | tlast
//   s_axis   | in        | in_byte[7:0]     | none           | end_of_text
//   m_axis   | out       | code_point[20:0] | is_replacement | final_result
//
// A byte is taken every cycle while the queue has room; the back part emits
// one result per cycle from a registered output stage, unless the output stalls or the queue is empty.
// A byte that ends a string inside a sequence yields up to three results,
// which the back part emits one after another from that entry.
// Synchronous active-high reset clears the sequence state, queue and output.
// Output stalls fill the queue, then lower s_axis_tready.
module utf8_to_code_point_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // code_point, then zero fill
  output logic        m_axis_tuser,   // is_replacement
  output logic        m_axis_tlast    // final_result
);
  import u8d_pkg::*;

  logic            q_full;
  logic            q_not_empty;
  logic            push;
  logic            pop;
  u8d_job_t        push_job;
  u8d_job_t        head;
  logic [CP_W-1:0] code_point;

  u8d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_byte     (s_axis_tdata),
    .end_of_text (s_axis_tlast),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  u8d_back u_back (
    .clk            (clk),
    .rst            (rst),
    .not_empty      (q_not_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .code_point     (code_point),
    .is_replacement (m_axis_tuser),
    .final_result   (m_axis_tlast)
  );

  assign m_axis_tdata = {(TDATA_OUT_W - CP_W)'(0), code_point};

endmodule

### tb/sv/tb_utf8_to_code_point_decoder_unit.sv
// Self-checking testbench for utf8_to_code_point_decoder_unit: directed byte table,
// then random strings, checked against a behavioral decoder kept inside this file.
// Depends on u8d_pkg and the decoder top level; needs no files or arguments.
module tb_utf8_to_code_point_decoder_unit;
  import u8d_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            repl;
    logic            last;
  } cp_result_t;

  typedef struct packed {
    logic [7:0]      b;
    logic            e;
    logic            typed;
    logic [CP_W-1:0] cp;
    logic            repl;
    logic            last;
  } byte_row_t;

  localparam int unsigned NUM_ROWS = 29;
  localparam byte_row_t BYTE_ROWS [NUM_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0, 1'b0},
    '{8'h7F, 1'b1, 1'b1, 21'h00007F, 1'b0, 1'b1},
    '{8'h80, 1'b0, 1'b1, REPL_CP,    1'b1, 1'b0},
    '{8'hBF, 1'b0, 1'b1, REPL_CP,    1'b1, 1'b0},
    '{8'hF8, 1'b0, 1'b1, REPL_CP,    1'b1, 1'b0},
    '{8'hFF, 1'b1, 1'b1, REPL_CP,    1'b1, 1'b1},
    '{8'hC2, 1'b1, 1'b1, REPL_CP,    1'b1, 1'b1},
    '{8'hC2, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hA9, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h82, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hAC, 1'b1, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hF7, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hEF, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hBD, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h82, 1'b1, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hE0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h41, 1'b1, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hA9, 1'b1, 1'b0, 21'h0, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  logic [7:0]  held_q [3];
  int unsigned held_n;
  int unsigned open_len;

  cp_result_t  step_out [$];
  cp_result_t  expected_cps [$];
  logic [8:0]  text_q [$];
  cp_result_t  want;

  bit          quiet;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned repl_seen;
  int unsigned ends_seen;
  int unsigned mismatch_count;
  int unsigned stuck_cycles;

  utf8_to_code_point_decoder_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  function automatic int unsigned lead_len(input logic [7:0] b);
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  function automatic logic [CP_W-1:0] lead_payload(input logic [7:0] b, input int unsigned len);
    if (len == 2) return CP_W'(b[4:0]);
    if (len == 3) return CP_W'(b[3:0]);
    return CP_W'(b[2:0]);
  endfunction

  task automatic add_result(input logic [CP_W-1:0] cp, input logic repl);
    step_out.insert(step_out.size(), {cp, repl, 1'b0});
  endtask

  // Advances the decoder state by one byte and queues the code points it yields.
  task automatic decode_byte(input logic [7:0] b, input logic e, input bit keep);
    logic [7:0]      run_q [3];
    logic [CP_W-1:0] cp;
    cp_result_t      tail;
    int unsigned     run_n;
    int unsigned     i;
    int unsigned     j;
    int unsigned     len;
    int unsigned     cnt;
    step_out.delete();
    if (open_len == 0) begin
      len = lead_len(b);
      if (b < 8'h80) begin
        add_result(CP_W'(b), 1'b0);
      end else if (len == 0 || e) begin
        add_result(REPL_CP, 1'b1);
      end else begin
        held_q[0] = b;
        held_n = 1;
        open_len = len;
      end
    end else begin
      cnt = (held_n == 0) ? 1 : held_n;
      if (cnt + 1 >= open_len) begin
        cp = lead_payload(held_q[0], open_len);
        for (j = 1; j < cnt; j++) cp = (cp << 6) | CP_W'(held_q[j][5:0]);
        cp = (cp << 6) | CP_W'(b[5:0]);
        add_result(cp, 1'b0);
        held_n = 0;
        open_len = 0;
      end else if (e) begin
        // The string ends mid-sequence: the lead is replaced and the rest is decoded afresh.
        add_result(REPL_CP, 1'b1);
        run_n = 0;
        for (j = 1; j < cnt && j < 3; j++) begin
          run_q[run_n] = held_q[j];
          run_n++;
        end
        run_q[run_n] = b;
        run_n++;
        i = 0;
        while (i < run_n) begin
          len = lead_len(run_q[i]);
          if (run_q[i] < 8'h80) begin
            add_result(CP_W'(run_q[i]), 1'b0);
            i++;
          end else if (len != 0 && i + len <= run_n) begin
            cp = lead_payload(run_q[i], len);
            for (j = 1; j < len; j++) cp = (cp << 6) | CP_W'(run_q[i + j][5:0]);
            add_result(cp, 1'b0);
            i += len;
          end else begin
            add_result(REPL_CP, 1'b1);
            i++;
          end
        end
        held_n = 0;
        open_len = 0;
      end else if (cnt < 3) begin
        held_q[cnt] = b;
        held_n = cnt + 1;
      end
    end
    if (e && step_out.size() > 0) begin
      tail = step_out.pop_back();
      tail.last = 1'b1;
      step_out.insert(step_out.size(), tail);
    end
    if (keep) begin
      foreach (step_out[k]) expected_cps.insert(expected_cps.size(), step_out[k]);
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic e, input bit typed,
                           input cp_result_t typed_res);
    while (!quiet && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= e;
    do @(posedge clk); while (!s_axis_tready);
    decode_byte(b, e, !typed);
    if (typed) expected_cps.insert(expected_cps.size(), typed_res);
    items_sent++;
    quiet = (items_sent >= 170 && items_sent < 290);
    @(negedge clk);
  endtask

  // Builds one string of mostly well-formed characters, with some noise bytes,
  // non-continuation followers and strings cut off inside a sequence.
  task automatic make_text();
    logic [7:0]  lead;
    logic [8:0]  tail;
    int unsigned n_chars;
    int unsigned c;
    int unsigned len;
    int unsigned k;
    int unsigned cut;
    bit          done;
    text_q.delete();
    n_chars = $urandom_range(12, 1);
    done = 1'b0;
    for (c = 0; c < n_chars && !done; c++) begin
      if ($urandom_range(99) < 12) begin
        text_q.insert(text_q.size(), {1'b0, 8'($urandom)});
      end else begin
        len = $urandom_range(4, 1);
        case (len)
          1: lead = 8'($urandom_range(127, 0));
          2: lead = {3'b110, 5'($urandom)};
          3: lead = {4'b1110, 4'($urandom)};
          default: lead = {5'b11110, 3'($urandom)};
        endcase
        text_q.insert(text_q.size(), {1'b0, lead});
        cut = (len > 1 && $urandom_range(99) < 10) ? $urandom_range(len - 1, 1) : len;
        for (k = 1; k < cut; k++) begin
          if ($urandom_range(99) < 8) text_q.insert(text_q.size(), {1'b0, 8'($urandom)});
          else text_q.insert(text_q.size(), {1'b0, 2'b10, 6'($urandom)});
        end
        if (cut < len) done = 1'b1;
      end
    end
    tail = text_q.pop_back();
    tail[8] = 1'b1;
    text_q.insert(text_q.size(), tail);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= quiet || $urandom_range(99) >= 13;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser) repl_seen++;
      if (m_axis_tlast) ends_seen++;
      if (expected_cps.size() == 0) begin
        $error("unexpected code point %h (replacement %b, final %b)",
               m_axis_tdata[CP_W-1:0], m_axis_tuser, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = expected_cps.pop_front();
        if (m_axis_tdata[CP_W-1:0] !== want.cp) begin
          $error("code_point: expected %h, got %h", want.cp, m_axis_tdata[CP_W-1:0]);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.repl) begin
          $error("is_replacement: expected %b, got %b", want.repl, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("final_result: expected %b, got %b", want.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    cp_result_t  row_res;
    logic [8:0]  next_byte;
    int unsigned r;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    quiet = 1'b0;
    items_sent = 0;
    results_seen = 0;
    repl_seen = 0;
    ends_seen = 0;
    mismatch_count = 0;
    stuck_cycles = 0;
    held_n = 0;
    open_len = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < NUM_ROWS; r++) begin
      row_res = {BYTE_ROWS[r].cp, BYTE_ROWS[r].repl, BYTE_ROWS[r].last};
      send_item(BYTE_ROWS[r].b, BYTE_ROWS[r].e, BYTE_ROWS[r].typed, row_res);
    end

    row_res = '0;
    while (items_sent < NUM_ROWS + RANDOM_ITEMS) begin
      make_text();
      while (text_q.size() > 0) begin
        next_byte = text_q.pop_front();
        send_item(next_byte[7:0], next_byte[8], 1'b0, row_res);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_cps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Fed %0d bytes in directed and random strings; checked %0d code points,",
             items_sent, results_seen);
    $display("%0d of them replacements and %0d marking the end of a string.",
             repl_seen, ends_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### utf8_to_code_point_decoder_unit.f
design/u8d_pkg.sv
design/u8d_front.sv
design/u8d_queue.sv
design/u8d_back.sv
design/utf8_to_code_point_decoder_unit.sv
tb/sv/tb_utf8_to_code_point_decoder_unit.sv
